// ===== sv/jfs_pkg.sv =====
// Shared constants, types and helpers for the five-point stencil sweep core.
// Depends on nothing; every other file imports it.
package jfs_pkg;

   localparam int MAX_GRID   = 1024;
   localparam int TEMP_BITS  = 16;
   localparam int MIN_GRID   = 3;
   localparam int SIZE_RESET = 256;
   localparam int CFG_BITS   = 11;
   localparam int GRID_BITS  = $clog2(MAX_GRID);
   localparam int SIZE_BITS  = $clog2(MAX_GRID + 1);
   localparam int SUM_BITS   = TEMP_BITS + 2;
   localparam int SQ_BITS    = 2 * TEMP_BITS;
   localparam int ACC_BITS   = 64;

   typedef struct packed {
      logic                 accept;
      logic [GRID_BITS-1:0] col;
      logic [GRID_BITS-1:0] col_next;
      logic [TEMP_BITS-1:0] temp;
   } lb_req_type;

   typedef struct packed {
      logic                 en;
      logic [GRID_BITS-1:0] col;
      logic [TEMP_BITS-1:0] data;
   } lb_wb_type;

   typedef struct packed {
      logic [TEMP_BITS-1:0] mid_c;
      logic [TEMP_BITS-1:0] mid_next;
      logic [TEMP_BITS-1:0] above_c;
   } lb_rd_type;

   typedef struct packed {
      logic [GRID_BITS-1:0] row;
      logic [GRID_BITS-1:0] col;
      logic                 clr;
      logic                 emit;
      logic                 last;
   } stage_type;

   typedef struct packed {
      stage_type            tag;
      logic [TEMP_BITS-1:0] temp;
   } cell_meta_type;

   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [CFG_BITS-1:0] g);
      if (int'(g) < MIN_GRID) begin
         return SIZE_BITS'(MIN_GRID);
      end else if (int'(g) > MAX_GRID) begin
         return SIZE_BITS'(MAX_GRID);
      end else begin
         return SIZE_BITS'(g);
      end
   endfunction

endpackage

// ===== sv/jfs_if.sv =====
// Valid/ready channel interfaces for cells in, updated cells out and the size register.
// Depends on jfs_pkg.
interface jfs_req_if;
   import jfs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [TEMP_BITS-1:0] cell_temp;
   logic                 frame_start;
   modport source(output valid, output cell_temp, output frame_start, input ready);
   modport sink(input valid, input cell_temp, input frame_start, output ready);
endinterface

interface jfs_rsp_if;
   import jfs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [GRID_BITS-1:0] out_row;
   logic [GRID_BITS-1:0] out_col;
   logic [TEMP_BITS-1:0] new_temp;
   logic [ACC_BITS-1:0]  diff_sum;
   logic                 sweep_last;
   modport source(output valid, output out_row, output out_col, output new_temp,
                  output diff_sum, output sweep_last, input ready);
   modport sink(input valid, input out_row, input out_col, input new_temp,
                input diff_sum, input sweep_last, output ready);
endinterface

interface jfs_csr_if;
   import jfs_pkg::*;
   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] grid_size;
   modport source(output valid, output grid_size, input ready);
   modport sink(input valid, input grid_size, output ready);
endinterface

// ===== sv/jacobi_five_point_stencil_sweep_core.sv =====
// Top level of the five-point stencil sweep: position counters, size register,
// line buffers and update pipeline. Depends on jfs_pkg, jfs_if, jfs_line_buf, jfs_update.
//
//   channel  dir   handshake      payload
//   req      in    valid/ready    cell_temp, frame_start
//   rsp      out   valid/ready    out_row, out_col, new_temp, diff_sum, sweep_last
//   csr      in    valid/ready    grid_size
//
// One cell per cycle unless stalled; the cell below a result goes via s1, s2, s3 to rsp.
// The rate is set by two reads of the middle row memory and one of the above row per cell.
// After reset all MAX_GRID (1024) row memory entries are cleared; req.ready is low then.
// A stalled rsp holds its register; cells are still taken until a cell with a result
// backs up behind it.
module jacobi_five_point_stencil_sweep_core (
   input  logic     clock,
   input  logic     reset,
   jfs_req_if.sink  req,
   jfs_rsp_if.source rsp,
   jfs_csr_if.sink  csr
);
   import jfs_pkg::*;

   logic [CFG_BITS-1:0]  grid_size_ff;
   logic [GRID_BITS-1:0] row_ff, row_in, col_ff, col_in;
   logic [SIZE_BITS-1:0] n;
   logic                 restart, accept, clearing, s1_free, at_last_col;
   logic [GRID_BITS-1:0] r, c;
   lb_req_type           lb_req;
   lb_wb_type            lb_wb;
   lb_rd_type            lb_rd;
   cell_meta_type        meta;

   assign csr.ready = 1'b1;
   assign req.ready = !clearing && s1_free;
   assign accept    = req.valid && req.ready;

   always_comb begin
      n       = clamp_size(grid_size_ff);
      restart = req.frame_start || (SIZE_BITS'(row_ff) >= n) || (SIZE_BITS'(col_ff) >= n);
      r       = restart ? '0 : row_ff;
      c       = restart ? '0 : col_ff;

      meta.temp     = req.cell_temp;
      meta.tag.row  = r - 1'b1;
      meta.tag.col  = c;
      meta.tag.clr  = (r == '0) && (c == '0);
      meta.tag.emit = (r >= GRID_BITS'(2)) && (c != '0)
                    && (SIZE_BITS'(c) <= n - SIZE_BITS'(2));
      meta.tag.last = (SIZE_BITS'(r) == n - SIZE_BITS'(1))
                    && (SIZE_BITS'(c) == n - SIZE_BITS'(2));

      at_last_col = SIZE_BITS'(c) == n - SIZE_BITS'(1);
      col_in      = at_last_col ? '0 : c + 1'b1;
      if (!at_last_col) begin
         row_in = r;
      end else if (SIZE_BITS'(r) == n - SIZE_BITS'(1)) begin
         row_in = '0;
      end else begin
         row_in = r + 1'b1;
      end

      lb_req.accept   = accept;
      lb_req.col      = c;
      lb_req.col_next = c + 1'b1;
      lb_req.temp     = req.cell_temp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= CFG_BITS'(SIZE_RESET);
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         if (csr.valid && csr.ready) begin
            grid_size_ff <= csr.grid_size;
         end
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   jfs_line_buf u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .req      (lb_req),
      .wb       (lb_wb),
      .rd       (lb_rd),
      .clearing (clearing)
   );

   jfs_update u_update (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .meta    (meta),
      .rd      (lb_rd),
      .s1_free (s1_free),
      .wb      (lb_wb),
      .rsp     (rsp)
   );

endmodule

// ===== sv/jfs_line_buf.sv =====
// Two row buffers (middle and above) in memories with registered reads, with a
// clearing pass after reset and write-first forwarding on the above buffer.
// Depends on jfs_pkg.
module jfs_line_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  jfs_pkg::lb_req_type    req,
   input  jfs_pkg::lb_wb_type     wb,
   output jfs_pkg::lb_rd_type     rd,
   output logic                   clearing
);
   import jfs_pkg::*;

   logic [TEMP_BITS-1:0] mid_mem   [MAX_GRID];
   logic [TEMP_BITS-1:0] above_mem [MAX_GRID];

   logic [GRID_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                 clearing_ff, clearing_in;
   logic [TEMP_BITS-1:0] mid_c_ff, mid_next_ff, above_c_ff;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == GRID_BITS'(MAX_GRID - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clearing_ff <= clearing_in;
      end
   end

   // middle row: read old values, then store the arriving cell
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mid_mem[clr_cnt_ff] <= '0;
      end else if (req.accept) begin
         mid_mem[req.col] <= req.temp;
      end
      if (req.accept) begin
         mid_c_ff    <= mid_mem[req.col];
         mid_next_ff <= mid_mem[req.col_next];
      end
   end

   // above row: the write-back from s1 can meet a read of the same column, so forward it
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         above_mem[clr_cnt_ff] <= '0;
      end else if (wb.en) begin
         above_mem[wb.col] <= wb.data;
      end
      if (req.accept) begin
         if (wb.en && wb.col == req.col) begin
            above_c_ff <= wb.data;
         end else begin
            above_c_ff <= above_mem[req.col];
         end
      end
   end

   assign rd.mid_c    = mid_c_ff;
   assign rd.mid_next = mid_next_ff;
   assign rd.above_c  = above_c_ff;
   assign clearing    = clearing_ff;

endmodule

// ===== sv/jfs_update.sv =====
// Elastic update pipeline: neighbor sum, squared change, saturating accumulator
// and output register. Depends on jfs_pkg and jfs_if.
module jfs_update (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  jfs_pkg::cell_meta_type meta,
   input  jfs_pkg::lb_rd_type     rd,
   output logic                   s1_free,
   output jfs_pkg::lb_wb_type     wb,
   jfs_rsp_if.source              rsp
);
   import jfs_pkg::*;

   logic                 s1_v_ff, s1_v_in;
   cell_meta_type        s1_ff;
   logic [TEMP_BITS-1:0] window_ff;

   logic                 s2_v_ff, s2_v_in;
   stage_type            s2_tag_ff;
   logic [TEMP_BITS-1:0] s2_nv_ff, s2_old_ff;

   logic                 s3_v_ff, s3_v_in;
   stage_type            s3_tag_ff;
   logic [TEMP_BITS-1:0] s3_nv_ff;
   logic [SQ_BITS-1:0]   s3_sq_ff;

   logic [ACC_BITS-1:0]  acc_ff, acc_in;

   logic                 out_v_ff, out_v_in;
   logic [GRID_BITS-1:0] out_row_ff, out_col_ff;
   logic [TEMP_BITS-1:0] out_temp_ff;
   logic [ACC_BITS-1:0]  out_sum_ff;
   logic                 out_last_ff;

   logic                 out_free, s3_go, s3_free, s2_go, s2_free, s1_go;
   logic [SUM_BITS-1:0]  nbr_sum;
   logic [TEMP_BITS-1:0] nv, diff;
   logic [ACC_BITS-1:0]  acc_base;
   logic [ACC_BITS:0]    acc_wide;

   always_comb begin
      out_free = !out_v_ff || rsp.ready;
      s3_go    = s3_v_ff && (!s3_tag_ff.emit || out_free);
      s3_free  = !s3_v_ff || s3_go;
      s2_go    = s2_v_ff && s3_free;
      s2_free  = !s2_v_ff || s2_go;
      s1_go    = s1_v_ff && s2_free;
      s1_free  = !s1_v_ff || s1_go;

      s1_v_in  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_ff);
      s2_v_in  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_ff);
      s3_v_in  = s2_go ? 1'b1 : (s3_go ? 1'b0 : s3_v_ff);

      nbr_sum = SUM_BITS'(rd.above_c) + SUM_BITS'(window_ff)
              + SUM_BITS'(s1_ff.temp) + SUM_BITS'(rd.mid_next);
      nv      = nbr_sum[SUM_BITS-1:2];

      diff = (s2_nv_ff >= s2_old_ff) ? (s2_nv_ff - s2_old_ff) : (s2_old_ff - s2_nv_ff);

      acc_base = s3_tag_ff.clr ? '0 : acc_ff;
      if (s3_tag_ff.emit) begin
         acc_wide = {1'b0, acc_base} + (ACC_BITS + 1)'(s3_sq_ff);
      end else begin
         acc_wide = {1'b0, acc_base};
      end
      acc_in = acc_wide[ACC_BITS] ? '1 : acc_wide[ACC_BITS-1:0];

      if (s3_go && s3_tag_ff.emit) begin
         out_v_in = 1'b1;
      end else if (rsp.ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end

      wb.en   = s1_go;
      wb.col  = s1_ff.tag.col;
      wb.data = rd.mid_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         window_ff <= '0;
         acc_ff    <= '0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         out_v_ff <= out_v_in;
         if (s1_go) begin
            window_ff <= rd.mid_c;
         end
         if (s3_go) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= meta;
      end
      if (s1_go) begin
         s2_tag_ff <= s1_ff.tag;
         s2_nv_ff  <= nv;
         s2_old_ff <= rd.mid_c;
      end
      if (s2_go) begin
         s3_tag_ff <= s2_tag_ff;
         s3_nv_ff  <= s2_nv_ff;
         s3_sq_ff  <= SQ_BITS'(diff) * SQ_BITS'(diff);
      end
      if (s3_go && s3_tag_ff.emit) begin
         out_row_ff  <= s3_tag_ff.row;
         out_col_ff  <= s3_tag_ff.col;
         out_temp_ff <= s3_nv_ff;
         out_sum_ff  <= acc_in;
         out_last_ff <= s3_tag_ff.last;
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.out_row    = out_row_ff;
   assign rsp.out_col    = out_col_ff;
   assign rsp.new_temp   = out_temp_ff;
   assign rsp.diff_sum   = out_sum_ff;
   assign rsp.sweep_last = out_last_ff;

endmodule

// ===== tb/jacobi_five_point_stencil_sweep_core_tb.sv =====
// Testbench for the five-point stencil sweep core: random valid/ready traffic on req
// and rsp and random csr size writes, checked against a cycle-free stencil predictor in a scoreboard.
// Depends on jfs_pkg, jfs_if and jacobi_five_point_stencil_sweep_core.
module jacobi_five_point_stencil_sweep_core_tb;
   import jfs_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned RANDOM_CELLS = 500;

   typedef struct packed {
      logic [GRID_BITS-1:0] row;
      logic [GRID_BITS-1:0] col;
      logic [TEMP_BITS-1:0] temp;
      logic [ACC_BITS-1:0]  sum;
      logic                 last;
   } cell_update_type;

   class stencil_scoreboard;
      logic [CFG_BITS-1:0]  size_reg;
      logic [TEMP_BITS-1:0] row_above [MAX_GRID];
      logic [TEMP_BITS-1:0] row_mid [MAX_GRID];
      logic [TEMP_BITS-1:0] left_mid;
      int unsigned          row_pos;
      int unsigned          col_pos;
      logic [ACC_BITS-1:0]  sq_acc;
      cell_update_type      pending [$];
      int unsigned          errors;

      function new();
         size_reg = CFG_BITS'(SIZE_RESET);
         foreach (row_above[i]) begin
            row_above[i] = '0;
            row_mid[i]   = '0;
         end
         left_mid = '0;
         row_pos  = 0;
         col_pos  = 0;
         sq_acc   = '0;
         errors   = 0;
      endfunction

      function void set_size(logic [CFG_BITS-1:0] v);
         size_reg = v;
      endfunction

      function void note_cell(logic [TEMP_BITS-1:0] t, logic fs);
         int unsigned          n;
         int unsigned          r;
         int unsigned          c;
         logic [TEMP_BITS-1:0] mid_c;
         logic [SUM_BITS-1:0]  nbr_sum;
         logic [TEMP_BITS-1:0] nv;
         logic [TEMP_BITS-1:0] delta;
         logic [SQ_BITS-1:0]   sq;
         logic [ACC_BITS-1:0]  full;
         cell_update_type      upd;
         n = int'(size_reg);
         if (n < MIN_GRID) n = MIN_GRID;
         if (n > MAX_GRID) n = MAX_GRID;
         full = '1;
         if (fs || row_pos >= n || col_pos >= n) begin
            row_pos = 0;
            col_pos = 0;
         end
         r = row_pos;
         c = col_pos;
         if (r == 0 && c == 0) sq_acc = '0;
         mid_c = row_mid[c];
         if (r >= 2 && c >= 1 && c <= n - 2) begin
            nbr_sum = SUM_BITS'(row_above[c]) + SUM_BITS'(left_mid) + SUM_BITS'(t)
                    + SUM_BITS'(row_mid[c+1]);
            nv    = nbr_sum[SUM_BITS-1:2];
            delta = (nv >= mid_c) ? nv - mid_c : mid_c - nv;
            sq    = SQ_BITS'(delta) * SQ_BITS'(delta);
            if (sq_acc > full - ACC_BITS'(sq)) sq_acc = full;
            else sq_acc = sq_acc + ACC_BITS'(sq);
            upd.row  = GRID_BITS'(r - 1);
            upd.col  = GRID_BITS'(c);
            upd.temp = nv;
            upd.sum  = sq_acc;
            upd.last = (r - 1 == n - 2) && (c == n - 2);
            pending.push_back(upd);
         end
         left_mid     = mid_c;
         row_above[c] = mid_c;
         row_mid[c]   = t;
         col_pos = c + 1;
         if (col_pos >= n) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= n) row_pos = 0;
         end
      endfunction

      function void check_update(cell_update_type got);
         cell_update_type exp_upd;
         if (pending.size() == 0) begin
            $error("unexpected update: row %0d col %0d", got.row, got.col);
            errors++;
            return;
         end
         exp_upd = pending.pop_front();
         if (got.row !== exp_upd.row) begin
            $error("out_row: expected %0d, got %0d", exp_upd.row, got.row);
            errors++;
         end
         if (got.col !== exp_upd.col) begin
            $error("out_col: expected %0d, got %0d", exp_upd.col, got.col);
            errors++;
         end
         if (got.temp !== exp_upd.temp) begin
            $error("new_temp: expected %h, got %h", exp_upd.temp, got.temp);
            errors++;
         end
         if (got.sum !== exp_upd.sum) begin
            $error("diff_sum: expected %h, got %h", exp_upd.sum, got.sum);
            errors++;
         end
         if (got.last !== exp_upd.last) begin
            $error("sweep_last: expected %0b, got %0b", exp_upd.last, got.last);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return pending.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm_run = 1'b0;
   int unsigned stall_left = 0;
   int unsigned cycles = 0;
   stencil_scoreboard sb = new();

   jfs_req_if req_ch();
   jfs_rsp_if rsp_ch();
   jfs_csr_if csr_ch();

   jacobi_five_point_stencil_sweep_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm_run || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [TEMP_BITS-1:0] pick_temp();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return TEMP_BITS'($urandom);
   endfunction

   function automatic int unsigned clamped(logic [CFG_BITS-1:0] v);
      if (v < MIN_GRID) return MIN_GRID;
      if (v > MAX_GRID) return MAX_GRID;
      return int'(v);
   endfunction

   always @(posedge clock) begin
      cell_update_type got;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) sb.set_size(csr_ch.grid_size);
         if (req_ch.valid && req_ch.ready) sb.note_cell(req_ch.cell_temp, req_ch.frame_start);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.row  = rsp_ch.out_row;
            got.col  = rsp_ch.out_col;
            got.temp = rsp_ch.new_temp;
            got.sum  = rsp_ch.diff_sum;
            got.last = rsp_ch.sweep_last;
            sb.check_update(got);
         end
      end
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 399) == 0) calm_run <= !calm_run;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!calm_run && $urandom_range(0, 7) == 0) stall_left <= idle_len() + 1;
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_cell(input logic [TEMP_BITS-1:0] t, input logic fs);
      int unsigned gap;
      gap = idle_len();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cell_temp   <= t;
      req_ch.frame_start <= fs;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_run(input int unsigned len, input logic with_start);
      for (int unsigned i = 0; i < len; i++) send_cell(pick_temp(), with_start && i == 0);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [CFG_BITS-1:0] v);
      csr_ch.valid     <= 1'b1;
      csr_ch.grid_size <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      logic [CFG_BITS-1:0] size_sel;
      int unsigned         n;
      int unsigned         kind;
      int unsigned         len;
      int unsigned         phase_goal;
      int unsigned         phase_cells;
      int unsigned         random_cells;
      req_ch.valid       = 1'b0;
      req_ch.cell_temp   = '0;
      req_ch.frame_start = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.grid_size   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (!req_ch.ready) @(posedge clock);

      // first sweep on reset counters: bright frame, dark center
      write_size('0);
      for (int unsigned i = 0; i < 9; i++) send_cell(i == 4 ? '0 : '1, 1'b0);
      // wrap into the next sweep, then break it with a frame start
      for (int unsigned i = 0; i < 5; i++) send_cell('0, 1'b0);
      for (int unsigned i = 0; i < 9; i++) send_cell(i[0] ? 16'hAAAA : 16'h5555, i == 0);
      settle();

      // largest grid: enough rows to reach the first interior row
      write_size('1);
      send_run(2 * MAX_GRID + 5, 1'b1);
      settle();
      write_size(CFG_BITS'(MAX_GRID - 1));
      send_run(40, 1'b1);
      settle();

      random_cells = 0;
      while (random_cells < RANDOM_CELLS) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) size_sel = CFG_BITS'($urandom_range(0, 2));
         else if (kind == 1) size_sel = CFG_BITS'($urandom_range(13, 24));
         else size_sel = CFG_BITS'($urandom_range(3, 10));
         write_size(size_sel);
         n = clamped(size_sel);
         phase_goal  = $urandom_range(60, 240);
         phase_cells = 0;
         while (phase_cells < phase_goal) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
               len = n * n;
               send_run(len, 1'b1);
            end else if (kind == 7) begin
               len = n * n;
               send_run(len, 1'b0);
            end else if (kind == 8) begin
               len = $urandom_range(1, n * n - 1);
               send_run(len, 1'b1);
            end else begin
               len = $urandom_range(1, 2 * n);
               for (int unsigned i = 0; i < len; i++)
                  send_cell(pick_temp(), $urandom_range(0, 5) == 0);
            end
            phase_cells += len;
         end
         random_cells += phase_cells;
         settle();
      end

      settle();
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
